@@ sv/one_pass_mean_variance_core_assert.svh @@
// Assertion macros for the mean/variance core
`ifndef ONE_PASS_MEAN_VARIANCE_CORE_ASSERT_SVH
`define ONE_PASS_MEAN_VARIANCE_CORE_ASSERT_SVH
// a implies b in the cycle after
`define OPMV_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
// a implies b in the same cycle
`define OPMV_ASSERT_NOW(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`endif

@@ sv/opmv_pkg.sv @@
`timescale 1ns / 1ps
package opmv_pkg;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_LOG2_DEF  = 20;
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 32;
  localparam int VAR_W    = 48;
  localparam int CNT_W    = 21;
  localparam int SUM_W    = 36;
  localparam int SQ_W     = 52;
  localparam int FRAC_W   = 16;
  // numerator (n*sumsq - sum^2) << 16, fits below 2^90 for default ranges
  localparam int NUM_W    = 96;
  localparam int DEN_W    = 2 * CNT_W;
  localparam int MCYC_W   = 3;

  // controller -> datapath commands
  typedef struct packed {
    logic accum;      // add sample into accumulators
    logic snap;       // capture accumulators, clear them
    logic mul_step;   // advance multiply sequence
    logic div_init;   // load divider
    logic div_step;   // one quotient bit
    logic load_out;   // move quotient to output register
  } opmv_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic mul_done;
    logic div_done;
  } opmv_stat_t;
endpackage

@@ sv/opmv_datapath.sv @@
`timescale 1ns / 1ps
module opmv_datapath import opmv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_LOG2  = COUNT_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] sample,
  input  opmv_cmd_t           cmd,
  output opmv_stat_t          stat,
  output logic [MEAN_W-1:0]   mean_fixed,
  output logic [VAR_W-1:0]    variance_fixed,
  output logic [CNT_W-1:0]    sample_count,
  output logic                overflow
);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(1) << COUNT_LOG2;
  localparam int DCNT_W  = $clog2(NUM_W + 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(NUM_W);
  // shared multiplier operand width and operand halves
  localparam int SQ_HALF  = SQ_W / 2;
  localparam int SUM_HALF = SUM_W / 2;
  localparam int MUL_W    = SQ_HALF;
  localparam logic [MCYC_W-1:0] MUL_LAST = MCYC_W'(6);

  logic [SUM_W-1:0] acc_sum;
  logic [SQ_W-1:0]  acc_sq;
  logic [CNT_W-1:0] acc_cnt;
  logic             acc_ovf;
  logic [SAMPLE_W-1:0] x;
  logic [2*SAMPLE_W-1:0] x_sq;

  // snapshot of a finished set
  logic [SUM_W-1:0] s_sum;
  logic [SQ_W-1:0]  s_sq;
  logic [CNT_W-1:0] s_cnt;
  logic             s_ovf;

  // product registers
  logic [MCYC_W-1:0] mcyc;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [2*MUL_W-1:0]    mul_p;
  logic [SQ_W+CNT_W-1:0] p_nsq;
  logic [2*SUM_W-1:0]    p_ss;
  logic [DEN_W-1:0]      p_nn;
  logic [NUM_W-1:0]      num;

  // restoring divider state, variance and mean paths
  logic [NUM_W-1:0]  dq;
  logic [DEN_W:0]    drem;
  logic [DCNT_W-1:0] dcnt;
  logic [NUM_W-1:0]  mq;
  logic [DEN_W:0]    mrem;
  logic [DEN_W:0]    dtry, mtry;
  logic [DEN_W-1:0]  mden;

  assign x    = sample & SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  assign x_sq = x * x;

  // running accumulators, saturate at the count limit
  always_ff @(posedge clk) begin
    if (rst || cmd.snap) begin
      acc_sum <= '0;
      acc_sq  <= '0;
      acc_cnt <= '0;
      acc_ovf <= 1'b0;
    end else if (cmd.accum) begin
      if (acc_cnt < LIMIT) begin
        acc_sum <= acc_sum + SUM_W'(x);
        acc_sq  <= acc_sq + SQ_W'(x_sq);
        acc_cnt <= acc_cnt + CNT_W'(1);
      end else begin
        acc_ovf <= 1'b1;
      end
    end
  end

  // snapshot includes the last sample's contribution
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      if (acc_cnt < LIMIT) begin
        s_sum <= acc_sum + SUM_W'(x);
        s_sq  <= acc_sq + SQ_W'(x_sq);
        s_cnt <= acc_cnt + CNT_W'(1);
        s_ovf <= acc_ovf;
      end else begin
        s_sum <= acc_sum;
        s_sq  <= acc_sq;
        s_cnt <= acc_cnt;
        s_ovf <= 1'b1;
      end
    end
  end

  // operand select for the shared multiplier, one partial product per step
  always_comb begin
    unique case (mcyc)
      3'd0: begin
        mul_a = MUL_W'(s_cnt);
        mul_b = s_sq[SQ_HALF-1:0];
      end
      3'd1: begin
        mul_a = MUL_W'(s_cnt);
        mul_b = s_sq[SQ_W-1:SQ_HALF];
      end
      3'd2: begin
        mul_a = MUL_W'(s_sum[SUM_HALF-1:0]);
        mul_b = MUL_W'(s_sum[SUM_HALF-1:0]);
      end
      3'd3: begin
        mul_a = MUL_W'(s_sum[SUM_HALF-1:0]);
        mul_b = MUL_W'(s_sum[SUM_W-1:SUM_HALF]);
      end
      3'd4: begin
        mul_a = MUL_W'(s_sum[SUM_W-1:SUM_HALF]);
        mul_b = MUL_W'(s_sum[SUM_W-1:SUM_HALF]);
      end
      3'd5: begin
        mul_a = MUL_W'(s_cnt);
        mul_b = MUL_W'(s_cnt);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // multiply sequence: n*sumsq in two steps, sum^2 in three, n*n, then subtract
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      mcyc <= '0;
    end else if (cmd.mul_step) begin
      unique case (mcyc)
        3'd0: p_nsq <= (SQ_W+CNT_W)'(mul_p);
        3'd1: p_nsq <= p_nsq + ((SQ_W+CNT_W)'(mul_p) << SQ_HALF);
        3'd2: p_ss  <= (2*SUM_W)'(mul_p);
        // cross term counted twice
        3'd3: p_ss  <= p_ss + ((2*SUM_W)'(mul_p) << (SUM_HALF + 1));
        3'd4: p_ss  <= p_ss + ((2*SUM_W)'(mul_p) << (2*SUM_HALF));
        3'd5: p_nn  <= mul_p[DEN_W-1:0];
        default: num <= (NUM_W'(p_nsq) - NUM_W'(p_ss)) << FRAC_W;
      endcase
      mcyc <= mcyc + MCYC_W'(1);
    end
  end
  assign stat.mul_done = (mcyc == MUL_LAST);

  // two restoring dividers run in lockstep, one bit per cycle
  assign dtry = {drem[DEN_W-1:0], dq[NUM_W-1]} - {1'b0, p_nn};
  assign mtry = {mrem[DEN_W-1:0], mq[NUM_W-1]} - {1'b0, mden};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq   <= num;
      drem <= '0;
      mq   <= NUM_W'({s_sum, FRAC_W'(0)});
      mrem <= '0;
      mden <= DEN_W'(s_cnt);
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (!dtry[DEN_W]) begin
        drem <= dtry;
        dq   <= {dq[NUM_W-2:0], 1'b1};
      end else begin
        drem <= {drem[DEN_W-1:0], dq[NUM_W-1]};
        dq   <= {dq[NUM_W-2:0], 1'b0};
      end
      if (!mtry[DEN_W]) begin
        mrem <= mtry;
        mq   <= {mq[NUM_W-2:0], 1'b1};
      end else begin
        mrem <= {mrem[DEN_W-1:0], mq[NUM_W-1]};
        mq   <= {mq[NUM_W-2:0], 1'b0};
      end
      dcnt <= dcnt + DCNT_W'(1);
    end
  end
  assign stat.div_done = (dcnt == DIV_LAST);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_fixed     <= mq[MEAN_W-1:0];
      variance_fixed <= dq[VAR_W-1:0];
      sample_count   <= s_cnt;
      overflow       <= s_ovf;
    end
  end
endmodule

@@ sv/opmv_ctrl.sv @@
`timescale 1ns / 1ps
module opmv_ctrl import opmv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  input  opmv_stat_t stat,
  output opmv_cmd_t  cmd
);
  typedef enum logic [2:0] {S_ACC, S_MUL, S_DINIT, S_DIV, S_OUT} state_t;
  state_t state;
  logic   xfer;

  assign in_ready = (state == S_ACC);
  assign xfer     = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.accum    = xfer && !last;
    cmd.snap     = xfer && last;
    cmd.mul_step = (state == S_MUL);
    cmd.div_init = (state == S_DINIT);
    cmd.div_step = (state == S_DIV) && !stat.div_done;
    cmd.load_out = (state == S_OUT) && !(out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_ACC:   if (xfer && last) state <= S_MUL;
        S_MUL:   if (stat.mul_done) state <= S_DINIT;
        S_DINIT: state <= S_DIV;
        S_DIV:   if (stat.div_done) state <= S_OUT;
        S_OUT:   if (cmd.load_out) state <= S_ACC;
        default: state <= S_ACC;
      endcase
    end
  end
endmodule

@@ sv/one_pass_mean_variance_core.sv @@
`timescale 1ns / 1ps
// Streaming population mean and variance.
// Input channel: sample, last with in_valid/in_ready. Samples not marked last
// are taken one per cycle and added into running sum, sum of squares, count.
// The transfer with last = 1 closes the set; after it the block forms the
// products (one shared 26x26 multiplier), loads the divider, runs a 96-bit
// bit-serial restoring divider and then loads the output register, which
// raises out_valid; the load waits until the output register is free.
// in_ready is low from the last transfer until the result is loaded.
// Output channel: mean_fixed (Q16.16), variance_fixed (Q32.16), sample_count,
// overflow with out_valid/out_ready, held in an output register. The next set
// may be accumulated while a result waits; a new result is not loaded until
// the prior one is taken, so a stalled receiver holds in_ready low.
// Beyond 2^COUNT_LOG2 samples further samples are dropped and overflow set.
// Reset (rst, synchronous) clears accumulators and empties the output.
module one_pass_mean_variance_core import opmv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_LOG2  = COUNT_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MEAN_W-1:0]   mean_fixed,
  output logic [VAR_W-1:0]    variance_fixed,
  output logic [CNT_W-1:0]    sample_count,
  output logic                overflow
);
  opmv_cmd_t  cmd;
  opmv_stat_t stat;

  opmv_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last, .out_valid, .out_ready,
    .stat, .cmd
  );

  opmv_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_LOG2(COUNT_LOG2)) u_dp (
    .clk, .rst, .sample, .cmd, .stat,
    .mean_fixed, .variance_fixed, .sample_count, .overflow
  );

`include "one_pass_mean_variance_core_assert.svh"
  `OPMV_ASSERT_NEXT(a_snap_blocks, cmd.snap, !in_ready, "input taken during compute")
  `OPMV_ASSERT_NOW(a_cnt_nonzero, out_valid, sample_count != '0, "empty set reported")
  `OPMV_ASSERT_NOW(a_one_cmd, cmd.div_step, !cmd.mul_step && !cmd.accum,
                   "divider overlaps other work")
endmodule

@@ dv/opmv_stats_checker.sv @@
`timescale 1ns / 1ps
module opmv_stats_checker import opmv_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [MEAN_W-1:0]   mean_fixed,
  input  logic [VAR_W-1:0]    variance_fixed,
  input  logic [CNT_W-1:0]    sample_count,
  input  logic                overflow,
  output int                  fail_count,
  output int                  results_due
);
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1) << COUNT_LOG2_DEF;

  typedef struct {
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
    logic [CNT_W-1:0]  count;
    logic              ovf;
  } set_stats_t;

  // running state of the set being gathered
  logic [SUM_W-1:0] acc_sum;
  logic [SQ_W-1:0]  acc_sq;
  logic [CNT_W-1:0] acc_count;
  logic             acc_ovf;
  set_stats_t       stats_due[$];

  // exact population mean and variance of the accumulated set
  function automatic set_stats_t compute_set_stats();
    set_stats_t  r;
    logic [127:0] n;
    logic [127:0] num;
    n          = 128'(acc_count);
    num        = (n * 128'(acc_sq) - 128'(acc_sum) * 128'(acc_sum)) << FRAC_W;
    r.mean     = MEAN_W'((128'(acc_sum) << FRAC_W) / n);
    r.variance = VAR_W'(num / (n * n));
    r.count    = acc_count;
    r.ovf      = acc_ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    set_stats_t exp_s;
    if (rst) begin
      acc_sum    = '0;
      acc_sq     = '0;
      acc_count  = '0;
      acc_ovf    = 1'b0;
      fail_count = 0;
      stats_due.delete();
    end else begin
      // input transfer: accumulate, saturating past the count limit
      if (in_valid && in_ready) begin
        if (acc_count < COUNT_LIMIT) begin
          acc_sum   = acc_sum + SUM_W'(sample);
          acc_sq    = acc_sq + SQ_W'(sample) * SQ_W'(sample);
          acc_count = acc_count + CNT_W'(1);
        end else begin
          acc_ovf = 1'b1;
        end
        if (last) begin
          stats_due.push_back(compute_set_stats());
          acc_sum   = '0;
          acc_sq    = '0;
          acc_count = '0;
          acc_ovf   = 1'b0;
        end
      end
      // output transfer: compare against oldest expectation
      if (out_valid && out_ready) begin
        if (stats_due.size() == 0) begin
          $display("%0t: unexpected result mean=%h var=%h count=%0d ovf=%b", $time,
                   mean_fixed, variance_fixed, sample_count, overflow);
          fail_count++;
        end else begin
          exp_s = stats_due.pop_front();
          if (mean_fixed !== exp_s.mean) begin
            $display("%0t: mean_fixed expected %h actual %h", $time, exp_s.mean,
                     mean_fixed);
            fail_count++;
          end
          if (variance_fixed !== exp_s.variance) begin
            $display("%0t: variance_fixed expected %h actual %h", $time,
                     exp_s.variance, variance_fixed);
            fail_count++;
          end
          if (sample_count !== exp_s.count) begin
            $display("%0t: sample_count expected %0d actual %0d", $time, exp_s.count,
                     sample_count);
            fail_count++;
          end
          if (overflow !== exp_s.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, exp_s.ovf, overflow);
            fail_count++;
          end
        end
      end
    end
    results_due = stats_due.size();
  end
endmodule

@@ dv/tb_one_pass_mean_variance_core.sv @@
`timescale 1ns / 1ps
module tb_one_pass_mean_variance_core;
  import opmv_pkg::*;

  localparam int MAX_CYCLES = 1_000_000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [MEAN_W-1:0]   mean_fixed;
  logic [VAR_W-1:0]    variance_fixed;
  logic [CNT_W-1:0]    sample_count;
  logic                overflow;
  int                  fail_count;
  int                  results_due;
  int                  idle_pct = 0;
  int                  stall_pct = 0;
  int                  cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  one_pass_mean_variance_core u_dut (.*);

  opmv_stats_checker u_chk (.*);

  // receiver backpressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one sample transfer, with optional idle gap first
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic l);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(15));
      default: return SAMPLE_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  initial begin
    int set_len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single-sample sets at both extremes, constant and spread sets
    send_sample('0, 1'b1);
    send_sample('1, 1'b1);
    for (int i = 0; i < 4; i++) send_sample('1, i == 3);
    for (int i = 0; i < 6; i++) send_sample((i % 2) ? '1 : '0, i == 5);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    for (int i = 0; i < 5; i++) send_sample(16'h5555 ^ SAMPLE_W'(i), i == 4);

    // random sets across idle/stall phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 87) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 25 : 87) : 0;
      for (int k = 0; k < 500; k += set_len) begin
        set_len = ($urandom_range(19) == 0) ? $urandom_range(40, 200)
                                            : $urandom_range(1, 24);
        send_set(set_len);
      end
    end
    in_valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;

    while (results_due != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
